// File: rtl/core/grid_maze_dfs_generator_assert.svh
// Assertion macros for the maze carving block.
// Same-cycle and next-cycle implications, both disabled during reset.
`ifndef GRID_MAZE_DFS_GENERATOR_ASSERT_SVH
`define GRID_MAZE_DFS_GENERATOR_ASSERT_SVH

`define GMD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gmd: same-cycle check failed");

`define GMD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gmd: next-cycle check failed");

`endif

// File: rtl/core/gmd_pkg.sv
`timescale 1ns / 1ps
package gmd_pkg;

  localparam int GMD_MAX_WIDTH  = 64;
  localparam int GMD_MAX_HEIGHT = 64;

  localparam int DIM_W      = 7;
  localparam int THR_W      = 17;
  localparam int PICK_W     = 8;
  localparam int MARK_W     = 16;
  localparam int OP_W       = 1;
  localparam int CELL_OUT_W = 12;
  localparam int CFG_IDX_W  = 2;

  localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MARK_THRESHOLD = 2'd2;

  // operations
  localparam logic [OP_W-1:0] OP_STEP    = 1'b0;
  localparam logic [OP_W-1:0] OP_RESTART = 1'b1;

  // neighbour scan order
  localparam logic [1:0] DIR_LEFT  = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_UP    = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  typedef struct packed {
    logic vis_we;
    logic vis_wbit;
    logic stk_we;
  } gmd_wr_ctl_t;

endpackage

// File: rtl/core/grid_maze_dfs_generator.sv
`timescale 1ns / 1ps
// Carving step: pop a cell, split it into column and row, scan its four neighbours,
//   pick one and push it; an empty stack skips to the result. One item at a time:
//   the shared shift-subtract divider (DW = max(cell bits, 8)) runs up to twice per
//   step (cell / width, then pick % count). Restart: the visited-map clearing sweep.
// Reset (rst, synchronous): registers to defaults, then the same clearing sweep over
//   all MAX_WIDTH*MAX_HEIGHT cells with input stalled; config writes always taken.
module grid_maze_dfs_generator #(
  parameter int MAX_WIDTH  = gmd_pkg::GMD_MAX_WIDTH,
  parameter int MAX_HEIGHT = gmd_pkg::GMD_MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst,
  // item channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [gmd_pkg::OP_W-1:0]        operation,
  input  logic [gmd_pkg::PICK_W-1:0]      rand_pick,
  input  logic [gmd_pkg::MARK_W-1:0]      rand_mark,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [gmd_pkg::CELL_OUT_W-1:0]  cell_res,
  output logic                            marked,
  output logic                            edge_valid,
  output logic [gmd_pkg::CELL_OUT_W-1:0]  neighbour,
  output logic                            done_res,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gmd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gmd_pkg::THR_W-1:0]       cfg_data
);
  import gmd_pkg::*;

  localparam int CELL_STORE = MAX_WIDTH * MAX_HEIGHT;
  localparam int CW         = $clog2(CELL_STORE);      // cell number bits
  localparam int SCW        = $clog2(CELL_STORE + 1);  // stack fill bits
  localparam int DW         = (CW > PICK_W) ? CW : PICK_W;
  localparam int AW         = CW + 1;                  // neighbour address, with headroom

  typedef enum logic [10:0] {
    S_CLEAR  = 11'b00000000001,
    S_IDLE   = 11'b00000000010,
    S_POP    = 11'b00000000100,
    S_LOAD   = 11'b00000001000,
    S_DIVX   = 11'b00000010000,
    S_NBADDR = 11'b00000100000,
    S_NBCHK  = 11'b00001000000,
    S_PICK   = 11'b00010000000,
    S_DIVP   = 11'b00100000000,
    S_PUSH   = 11'b01000000000,
    S_FIN    = 11'b10000000000
  } gmd_state_t;

  gmd_state_t state, state_next;

  // ---------------------------------------------------------------------------
  // Configuration registers. Always ready; unknown indexes are dropped.
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0] grid_width;
  logic [DIM_W-1:0] grid_height;
  logic [THR_W-1:0] mark_threshold;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width     <= DIM_RESET;
      grid_height    <= DIM_RESET;
      mark_threshold <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GRID_WIDTH:     grid_width     <= cfg_data[DIM_W-1:0];
        CFG_GRID_HEIGHT:    grid_height    <= cfg_data[DIM_W-1:0];
        CFG_MARK_THRESHOLD: mark_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // Zero reads as one, anything above the build maximum reads as the maximum.
  logic [DIM_W-1:0] w_clamp, h_clamp;

  always_comb begin
    if (grid_width == '0) begin
      w_clamp = DIM_W'(1);
    end else if (32'(grid_width) > $unsigned(MAX_WIDTH)) begin
      w_clamp = DIM_W'(MAX_WIDTH);
    end else begin
      w_clamp = grid_width;
    end
    if (grid_height == '0) begin
      h_clamp = DIM_W'(1);
    end else if (32'(grid_height) > $unsigned(MAX_HEIGHT)) begin
      h_clamp = DIM_W'(MAX_HEIGHT);
    end else begin
      h_clamp = grid_height;
    end
  end

  // ---------------------------------------------------------------------------
  // Working registers
  // ---------------------------------------------------------------------------
  logic [CW-1:0]    clr_addr;     // clearing sweep position
  logic             clr_reply;    // sweep came from a restart: answer with a beat
  logic [SCW-1:0]   stack_count;
  logic [PICK_W-1:0] pick_q;
  logic [CW-1:0]    cell_q;       // popped cell
  logic [DIM_W-1:0] x_q;          // column of popped cell
  logic [DW-1:0]    y_q;          // row of popped cell
  logic [1:0]       dir;          // neighbour being scanned
  logic [CW-1:0]    nb_addr;      // neighbour whose visited bit is in flight
  logic [CW-1:0]    cand [4];
  logic [2:0]       cand_n;
  logic [CW-1:0]    nb_q;         // chosen neighbour

  // result under construction
  logic [CW-1:0]    res_cell;
  logic             res_marked;
  logic             res_edge;
  logic [CW-1:0]    res_nb;
  logic             res_done;

  // shared divider
  logic             div_start;
  logic [DW-1:0]    div_dividend;
  logic [DIM_W-1:0] div_divisor;
  logic             div_busy;
  logic [DW-1:0]    div_quo;
  logic [DIM_W-1:0] div_rem;

  // store ports
  gmd_wr_ctl_t      wr;
  logic [CW-1:0]    vis_waddr, vis_raddr;
  logic             vis_rdata;
  logic [CW-1:0]    stk_waddr, stk_wdata, stk_raddr, stk_rdata;

  logic             in_take;
  logic             out_free;
  logic [SCW-1:0]   count_p1;
  logic             push_nb;

  assign in_take  = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // After the pop the popped cell goes back into its own slot unchanged, so only
  // the count moves; the neighbour goes above it if the stack has room.
  assign count_p1 = stack_count + SCW'(1);
  assign push_nb  = count_p1 < SCW'(CELL_STORE);

  // ---------------------------------------------------------------------------
  // Neighbour address for the current scan direction
  // ---------------------------------------------------------------------------
  logic [AW-1:0] cell_ext, w_ext, nb_c;
  logic          nb_in_grid, nb_ok;

  assign cell_ext = AW'(cell_q);
  assign w_ext    = AW'(w_clamp);

  always_comb begin
    unique case (dir)
      DIR_LEFT: begin
        nb_in_grid = (x_q != '0);
        nb_c       = cell_ext - AW'(1);
      end
      DIR_RIGHT: begin
        nb_in_grid = ({1'b0, x_q} + (DIM_W+1)'(1)) < {1'b0, w_clamp};
        nb_c       = cell_ext + AW'(1);
      end
      DIR_UP: begin
        nb_in_grid = (y_q != '0);
        nb_c       = cell_ext - w_ext;
      end
      DIR_DOWN: begin
        // rows at or past the current height have no lower neighbour
        nb_in_grid = ((DW+1)'(y_q) + (DW+1)'(1)) < (DW+1)'(h_clamp);
        nb_c       = cell_ext + w_ext;
      end
      default: begin
        nb_in_grid = 1'b0;
        nb_c       = '0;
      end
    endcase
    nb_ok = nb_in_grid && (nb_c < AW'(CELL_STORE));
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == CW'(CELL_STORE - 1)) begin
          state_next = clr_reply ? S_FIN : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_take) begin
          if (operation == OP_RESTART) begin
            state_next = S_CLEAR;
          end else if (stack_count == '0) begin
            state_next = S_FIN;
          end else begin
            state_next = S_POP;
          end
        end
      end
      S_POP:  state_next = S_LOAD;
      S_LOAD: state_next = S_DIVX;
      S_DIVX: begin
        if (!div_busy) begin
          state_next = S_NBADDR;
        end
      end
      S_NBADDR: begin
        if (nb_ok) begin
          state_next = S_NBCHK;
        end else if (dir == DIR_DOWN) begin
          state_next = S_PICK;
        end
      end
      S_NBCHK: state_next = (dir == DIR_DOWN) ? S_PICK : S_NBADDR;
      S_PICK:  state_next = (cand_n == '0) ? S_FIN : S_DIVP;
      S_DIVP: begin
        if (!div_busy) begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: state_next = S_FIN;
      S_FIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Divider: cell / width after the pop, then pick % candidate count.
  always_comb begin
    div_start    = 1'b0;
    div_dividend = DW'(stk_rdata);
    div_divisor  = w_clamp;
    if (state == S_LOAD) begin
      div_start = 1'b1;
    end else if (state == S_PICK) begin
      div_start    = (cand_n != '0);
      div_dividend = DW'(pick_q);
      div_divisor  = DIM_W'(cand_n);
    end
  end

  // Store writes: the sweep clears the map (cell zero set) and seeds stack entry
  // zero; a carving step marks the neighbour and stacks it if the stack has room.
  always_comb begin
    wr        = '0;
    vis_waddr = nb_q;
    stk_waddr = count_p1[CW-1:0];
    stk_wdata = nb_q;
    if (state == S_CLEAR) begin
      wr.vis_we   = 1'b1;
      wr.vis_wbit = (clr_addr == '0);
      wr.stk_we   = (clr_addr == '0);
      vis_waddr   = clr_addr;
      stk_waddr   = '0;
      stk_wdata   = '0;
    end else if (state == S_PUSH) begin
      wr.vis_we   = 1'b1;
      wr.vis_wbit = 1'b1;
      wr.stk_we   = push_nb;
    end
  end

  assign vis_raddr = nb_c[CW-1:0];
  assign stk_raddr = SCW'(stack_count - SCW'(1)) < SCW'(CELL_STORE)
                     ? stack_count[CW-1:0] - CW'(1) : '0;

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      clr_reply   <= 1'b0;
      stack_count <= SCW'(1);
    end else begin
      state <= state_next;
      unique case (state)
        S_CLEAR: clr_addr <= clr_addr + CW'(1);
        S_IDLE: begin
          if (in_take && operation == OP_RESTART) begin
            clr_addr    <= '0;
            clr_reply   <= 1'b1;
            stack_count <= SCW'(1);
          end
        end
        S_POP:  stack_count <= stack_count - SCW'(1);
        S_PUSH: stack_count <= push_nb ? stack_count + SCW'(2) : count_p1;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_take) begin
          pick_q     <= rand_pick;
          res_cell   <= '0;
          res_edge   <= 1'b0;
          res_nb     <= '0;
          res_done   <= (operation == OP_STEP) && (stack_count == '0);
          res_marked <= (operation == OP_STEP) && (stack_count != '0) &&
                        ({1'b0, rand_mark} < mark_threshold);
        end
      end
      S_LOAD: begin
        // popped cell arrives from the stack read
        cell_q   <= stk_rdata;
        res_cell <= stk_rdata;
      end
      S_DIVX: begin
        x_q    <= div_rem;
        y_q    <= div_quo;
        dir    <= DIR_LEFT;
        cand_n <= '0;
      end
      S_NBADDR: begin
        nb_addr <= nb_c[CW-1:0];
        if (!nb_ok) begin
          dir <= dir + 2'd1;
        end
      end
      S_NBCHK: begin
        if (!vis_rdata) begin
          cand[cand_n[1:0]] <= nb_addr;
          cand_n            <= cand_n + 3'd1;
        end
        dir <= dir + 2'd1;
      end
      S_DIVP: nb_q <= cand[div_rem[1:0]];
      S_PUSH: begin
        res_edge <= 1'b1;
        res_nb   <= nb_q;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Output register: holds a beat while the next item is taken in.
  // ---------------------------------------------------------------------------
  logic [CW+CELL_OUT_W-1:0] cell_wide, nb_wide;

  assign cell_wide = {{CELL_OUT_W{1'b0}}, res_cell};
  assign nb_wide   = {{CELL_OUT_W{1'b0}}, res_nb};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      cell_res   <= cell_wide[CELL_OUT_W-1:0];
      marked     <= res_marked;
      edge_valid <= res_edge;
      neighbour  <= nb_wide[CELL_OUT_W-1:0];
      done_res   <= res_done;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared units
  // ---------------------------------------------------------------------------
  gmd_div #(
    .DW (DW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  gmd_store #(
    .DEPTH (CELL_STORE),
    .CW    (CW)
  ) u_store (
    .clk       (clk),
    .wr        (wr),
    .vis_waddr (vis_waddr),
    .vis_raddr (vis_raddr),
    .vis_rdata (vis_rdata),
    .stk_waddr (stk_waddr),
    .stk_wdata (stk_wdata),
    .stk_raddr (stk_raddr),
    .stk_rdata (stk_rdata)
  );

endmodule

// File: rtl/core/gmd_div.sv
`timescale 1ns / 1ps
module gmd_div #(
  parameter int DW = 12
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [DW-1:0]              dividend,
  input  logic [gmd_pkg::DIM_W-1:0]  divisor,
  output logic                       busy,
  output logic [DW-1:0]              quotient,
  output logic [gmd_pkg::DIM_W-1:0]  remainder
);
  import gmd_pkg::*;

  localparam int CNT_W = $clog2(DW);

  logic [CNT_W-1:0] cnt;
  logic [DIM_W-1:0] dvs;
  logic [DIM_W:0]   rem_sh;
  logic             ge;

  // one restoring shift-subtract step per cycle
  assign rem_sh = {remainder, quotient[DW-1]};
  assign ge     = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DW - 1);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
    end else if (busy) begin
      quotient  <= {quotient[DW-2:0], ge};
      remainder <= ge ? DIM_W'(rem_sh - {1'b0, dvs}) : rem_sh[DIM_W-1:0];
    end
  end

endmodule

// File: rtl/core/gmd_store.sv
`timescale 1ns / 1ps
module gmd_store #(
  parameter int DEPTH = 4096,
  parameter int CW    = 12
) (
  input  logic                 clk,
  input  gmd_pkg::gmd_wr_ctl_t wr,
  input  logic [CW-1:0]        vis_waddr,
  input  logic [CW-1:0]        vis_raddr,
  output logic                 vis_rdata,
  input  logic [CW-1:0]        stk_waddr,
  input  logic [CW-1:0]        stk_wdata,
  input  logic [CW-1:0]        stk_raddr,
  output logic [CW-1:0]        stk_rdata
);
  import gmd_pkg::*;

  logic          vis_mem [DEPTH];
  logic [CW-1:0] stk_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.vis_we) begin
      vis_mem[vis_waddr] <= wr.vis_wbit;
    end
    vis_rdata <= vis_mem[vis_raddr];
  end

  always_ff @(posedge clk) begin
    if (wr.stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_rdata <= stk_mem[stk_raddr];
  end

endmodule

// File: rtl/core/gmd_chk.sv
`timescale 1ns / 1ps
`include "grid_maze_dfs_generator_assert.svh"
module gmd_chk (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic [gmd_pkg::OP_W-1:0]        operation,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [gmd_pkg::CELL_OUT_W-1:0]  cell_res,
  input logic                            marked,
  input logic                            edge_valid,
  input logic [gmd_pkg::CELL_OUT_W-1:0]  neighbour,
  input logic                            done_res
);
  import gmd_pkg::*;

  // an empty-stack beat carries nothing else
  `GMD_ASSERT_NOW(a_done_clean, clk, rst, out_valid && done_res, !edge_valid && !marked && cell_res == '0 && neighbour == '0)
  // a carved passage joins two different cells
  `GMD_ASSERT_NOW(a_edge_pair, clk, rst, out_valid && edge_valid, !done_res && neighbour != cell_res)
  // a stalled beat holds
  `GMD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(cell_res) && $stable(neighbour) && $stable(edge_valid))
  // a restart starts the clearing sweep
  `GMD_ASSERT_NEXT(a_restart_busy, clk, rst, in_valid && !in_stall && operation == OP_RESTART, in_stall)

endmodule

bind grid_maze_dfs_generator gmd_chk u_gmd_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .operation  (operation),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .cell_res   (cell_res),
  .marked     (marked),
  .edge_valid (edge_valid),
  .neighbour  (neighbour),
  .done_res   (done_res)
);

// File: bench/tb_grid_maze_dfs_generator.sv
`timescale 1ns / 1ps
// Check the depth-first maze carving block against a cycle-free model of the
// carving walk. Every accepted beat updates the model and queues the result it
// must produce; a monitor pops and compares each result beat field by field.
module tb_grid_maze_dfs_generator;
  import gmd_pkg::*;

  localparam int MAX_W       = GMD_MAX_WIDTH;
  localparam int MAX_H       = GMD_MAX_HEIGHT;
  localparam int CELLS       = MAX_W * MAX_H;
  localparam int RANDOM_BEATS = 690;
  // Restart sweeps dominate a run in which every maze is a single cell; a typical
  // run needs far less.
  localparam int CYCLE_LIMIT = 5000000;
  localparam int SETTLE_CYCLES = 64;
  // register index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct {
    logic [CELL_OUT_W-1:0] cell_no;
    logic                  mark_bit;
    logic                  carved;
    logic [CELL_OUT_W-1:0] nb_cell;
    logic                  empty_stack;
  } carve_t;

  logic clk;
  logic rst = 1'b1;

  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic [OP_W-1:0]       operation = OP_STEP;
  logic [PICK_W-1:0]     rand_pick = '0;
  logic [MARK_W-1:0]     rand_mark = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [CELL_OUT_W-1:0] cell_res;
  logic                  marked;
  logic                  edge_valid;
  logic [CELL_OUT_W-1:0] neighbour;
  logic                  done_res;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [THR_W-1:0]      cfg_data  = '0;

  grid_maze_dfs_generator dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .rand_pick  (rand_pick),
    .rand_mark  (rand_mark),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cell_res   (cell_res),
    .marked     (marked),
    .edge_valid (edge_valid),
    .neighbour  (neighbour),
    .done_res   (done_res),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Carving walk model: own copy of registers, visited bitmap and cell stack.
  // ---------------------------------------------------------------------------
  int unsigned width_reg;
  int unsigned height_reg;
  int unsigned thresh_reg;
  bit          visited [CELLS];
  int unsigned cell_stack_mem [CELLS];
  int unsigned stack_depth;

  carve_t carve_queue [$];
  int     mismatches = 0;
  int     beats_sent;
  int     cycle_count = 0;
  bit     sender_gaps_on = 1'b1;

  function automatic void restart_carving();
    foreach (visited[i]) visited[i] = 1'b0;
    visited[0]        = 1'b1;
    cell_stack_mem[0] = 0;
    stack_depth       = 1;
  endfunction

  // Zero reads as one; anything past the grid maximum reads as the maximum.
  function automatic int unsigned clamp_dim(int unsigned v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic bit is_open(int unsigned c);
    return (c < CELLS) && !visited[c];
  endfunction

  // Pushes onto a full stack are dropped.
  function automatic void stack_push(int unsigned c);
    if (stack_depth < CELLS) begin
      cell_stack_mem[stack_depth] = c;
      stack_depth++;
    end
  endfunction

  function automatic carve_t carve_step(logic [OP_W-1:0] op, logic [PICK_W-1:0] pick,
                                        logic [MARK_W-1:0] mk);
    carve_t      r;
    int unsigned w, h, cur, x, y, n, nb;
    int unsigned cand [4];
    r = '{default: '0};
    n = 0;
    if (op == OP_RESTART) begin
      restart_carving();
      return r;
    end
    if (stack_depth == 0) begin
      r.empty_stack = 1'b1;
      return r;
    end
    w = clamp_dim(width_reg, MAX_W);
    h = clamp_dim(height_reg, MAX_H);
    stack_depth--;
    cur = cell_stack_mem[stack_depth];
    r.cell_no  = cur[CELL_OUT_W-1:0];
    r.mark_bit = (mk < thresh_reg);
    // Decode with the current width; rows past the current height get no
    // lower neighbour.
    x = cur % w;
    y = cur / w;
    if (x > 0 && is_open(cur - 1)) begin
      cand[n] = cur - 1;
      n++;
    end
    if (x + 1 < w && is_open(cur + 1)) begin
      cand[n] = cur + 1;
      n++;
    end
    if (y > 0 && is_open(cur - w)) begin
      cand[n] = cur - w;
      n++;
    end
    if (y + 1 < h && is_open(cur + w)) begin
      cand[n] = cur + w;
      n++;
    end
    if (n > 0) begin
      nb = cand[pick % n];
      visited[nb] = 1'b1;
      stack_push(cur);
      stack_push(nb);
      r.carved  = 1'b1;
      r.nb_cell = nb[CELL_OUT_W-1:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Item channel driver.
  // ---------------------------------------------------------------------------
  function automatic int sender_gap();
    int r;
    if (!sender_gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // Send one beat and queue its result once it is taken. Returns on the
  // accepting edge with valid still high, so back-to-back beats never drop it.
  task automatic send_beat(input logic [OP_W-1:0] op, input logic [PICK_W-1:0] pick,
                           input logic [MARK_W-1:0] mk);
    int     gap;
    carve_t exp_res;
    gap = sender_gap();
    if (gap > 0) begin
      if (in_valid) in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    rand_pick <= pick;
    rand_mark <= mk;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    exp_res = carve_step(op, pick, mk);
    carve_queue.insert(carve_queue.size(), exp_res);
    beats_sent++;
  endtask

  // Hold off the sender until every queued result has come back.
  task automatic drain_results();
    if (in_valid) in_valid <= 1'b0;
    while (carve_queue.size() != 0) @(posedge clk);
  endtask

  // Register writes happen only with the block idle; every beat yields a
  // result, so an empty queue means nothing is in flight.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] data);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_GRID_WIDTH:     width_reg  = data[DIM_W-1:0];
      CFG_GRID_HEIGHT:    height_reg = data[DIM_W-1:0];
      CFG_MARK_THRESHOLD: thresh_reg = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Dimension word with random junk above the 7 register bits.
  function automatic logic [THR_W-1:0] dim_word(int unsigned dim);
    logic [THR_W-1:0] d;
    d = THR_W'($urandom);
    d[DIM_W-1:0] = dim[DIM_W-1:0];
    return d;
  endfunction

  // Mostly small grids so mazes finish; a few at the extremes or out of range.
  function automatic int unsigned pick_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 6);
    if (r < 80) return $urandom_range(7, 16);
    if (r < 88) return MAX_W;
    if (r < 93) return 0;
    if (r < 97) return $urandom_range(65, 127);
    return $urandom_range(17, 63);
  endfunction

  function automatic logic [THR_W-1:0] pick_threshold();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return '0;
    if (r < 40) return 17'h10000;
    if (r < 45) return 17'h1FFFF;
    if (r < 55) return THR_W'($urandom_range(17'h10001, 17'h1FFFF));
    return THR_W'($urandom_range(0, 17'hFFFF));
  endfunction

  // ---------------------------------------------------------------------------
  // Result channel: random stall pattern plus checker.
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      int r, len;
      bit hold;
      r = $urandom_range(0, 99);
      if (r < 55) begin
        hold = 1'b0;
        len  = $urandom_range(1, 4);
      end else if (r < 85) begin
        hold = 1'b1;
        len  = $urandom_range(1, 3);
      end else if (r < 93) begin
        hold = 1'b1;
        len  = $urandom_range(10, 40);
      end else begin
        // stretch with no back-pressure at all
        hold = 1'b0;
        len  = $urandom_range(40, 120);
      end
      out_stall <= hold;
      repeat (len) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    carve_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got.cell_no     = cell_res;
      got.mark_bit    = marked;
      got.carved      = edge_valid;
      got.nb_cell     = neighbour;
      got.empty_stack = done_res;
      if (carve_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: cell %0d marked %0b edge %0b nb %0d done %0b",
                   got.cell_no, got.mark_bit, got.carved, got.nb_cell, got.empty_stack);
      end else begin
        want = carve_queue.pop_front();
        if (got.cell_no !== want.cell_no || got.mark_bit !== want.mark_bit ||
            got.carved !== want.carved || got.nb_cell !== want.nb_cell ||
            got.empty_stack !== want.empty_stack) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected cell %0d marked %0b edge %0b nb %0d done %0b",
                     want.cell_no, want.mark_bit, want.carved, want.nb_cell,
                     want.empty_stack);
            $display("          got      cell %0d marked %0b edge %0b nb %0d done %0b",
                     got.cell_no, got.mark_bit, got.carved, got.nb_cell,
                     got.empty_stack);
          end
        end
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Carve from cell zero on the 64 x 64 reset grid with threshold zero, so no
  // cell is marked even for the largest random value.
  task automatic test_reset_defaults();
    send_beat(OP_STEP, 8'h00, 16'h0000);
    send_beat(OP_STEP, 8'hFF, 16'hFFFF);
    send_beat(OP_STEP, 8'h80, 16'h0001);
    send_beat(OP_STEP, 8'h7F, 16'h8000);
  endtask

  task automatic test_register_extremes();
    // Single-cell grid: cell zero has no neighbour, then the stack runs empty.
    // A threshold of 65536 marks every popped cell.
    write_reg(CFG_GRID_WIDTH, dim_word(1));
    write_reg(CFG_GRID_HEIGHT, dim_word(1));
    write_reg(CFG_MARK_THRESHOLD, 17'h10000);
    send_beat(OP_RESTART, 8'hFF, 16'hFFFF);
    send_beat(OP_STEP, 8'hFF, 16'hFFFF);
    send_beat(OP_STEP, 8'h00, 16'h0000);
    send_beat(OP_STEP, 8'hA5, 16'h5A5A);
    // Zero dimensions read as one; largest threshold field value.
    write_reg(CFG_GRID_WIDTH, 17'h1FF80);
    write_reg(CFG_GRID_HEIGHT, 17'h00000);
    write_reg(CFG_MARK_THRESHOLD, 17'h1FFFF);
    send_beat(OP_RESTART, 8'h00, 16'h0000);
    send_beat(OP_STEP, 8'h01, 16'hFFFF);
    // Oversized dimensions read as the maximum; threshold one marks only zero.
    write_reg(CFG_GRID_WIDTH, 17'h1FFFF);
    write_reg(CFG_GRID_HEIGHT, dim_word(65));
    write_reg(CFG_MARK_THRESHOLD, 17'h00001);
    send_beat(OP_RESTART, 8'h55, 16'hAAAA);
    send_beat(OP_STEP, 8'h01, 16'h0000);
    send_beat(OP_STEP, 8'h02, 16'h0001);
    // Unused register index: no effect on anything.
    write_reg(CFG_SPARE, THR_W'($urandom));
  endtask

  // Carve down an 8 x 8 grid, then one step right; then shrink the grid under the stack so
  // popped cells decode with the new width and sit below the last row.
  task automatic test_mid_generation_resize();
    write_reg(CFG_GRID_WIDTH, dim_word(8));
    write_reg(CFG_GRID_HEIGHT, dim_word(8));
    write_reg(CFG_MARK_THRESHOLD, 17'h08000);
    send_beat(OP_RESTART, 8'h00, 16'h0000);
    send_beat(OP_STEP, 8'h01, 16'h7FFF);
    send_beat(OP_STEP, 8'h01, 16'h8000);
    send_beat(OP_STEP, 8'h01, 16'h0000);
    send_beat(OP_STEP, 8'h00, 16'hFFFF);
    write_reg(CFG_GRID_WIDTH, dim_word(5));
    write_reg(CFG_GRID_HEIGHT, dim_word(2));
    repeat (4) send_beat(OP_STEP, PICK_W'($urandom), MARK_W'($urandom));
  endtask

  // Full 4 x 4 maze with no sender gaps, run until the stack is empty and past.
  task automatic test_back_to_back();
    write_reg(CFG_GRID_WIDTH, dim_word(4));
    write_reg(CFG_GRID_HEIGHT, dim_word(4));
    write_reg(CFG_MARK_THRESHOLD, pick_threshold());
    sender_gaps_on = 1'b0;
    send_beat(OP_RESTART, PICK_W'($urandom), MARK_W'($urandom));
    repeat (35) send_beat(OP_STEP, PICK_W'($urandom), MARK_W'($urandom));
    sender_gaps_on = 1'b1;
    drain_results();
  endtask

  // Whole mazes with random content on random grids; a little noise from stray
  // restarts and grid changes in the middle of a walk.
  task automatic test_random_mazes();
    int          start, steps, r;
    int unsigned w, h;
    start = beats_sent;
    while (beats_sent - start < RANDOM_BEATS) begin
      w = pick_dim();
      h = pick_dim();
      write_reg(CFG_GRID_WIDTH, dim_word(w));
      write_reg(CFG_GRID_HEIGHT, dim_word(h));
      if ($urandom_range(0, 2) == 0) write_reg(CFG_MARK_THRESHOLD, pick_threshold());
      send_beat(OP_RESTART, PICK_W'($urandom), MARK_W'($urandom));
      // A full walk takes 2*cells-1 steps; run 2 to 5 past it to see the end, but cap long walks at 24 to 48 steps.
      steps = 2 * clamp_dim(w, MAX_W) * clamp_dim(h, MAX_H) + $urandom_range(1, 4);
      if (steps > 48) steps = $urandom_range(24, 48);
      repeat (steps) begin
        r = $urandom_range(0, 99);
        if (r < 2) begin
          send_beat(OP_RESTART, PICK_W'($urandom), MARK_W'($urandom));
        end else if (r < 4) begin
          write_reg($urandom_range(0, 1) ? CFG_GRID_HEIGHT : CFG_GRID_WIDTH,
                    dim_word(pick_dim()));
          send_beat(OP_STEP, PICK_W'($urandom), MARK_W'($urandom));
        end else begin
          send_beat(OP_STEP, PICK_W'($urandom), MARK_W'($urandom));
        end
      end
    end
  endtask

  initial begin
    beats_sent  = 0;
    width_reg   = DIM_RESET;
    height_reg  = DIM_RESET;
    thresh_reg  = 0;
    restart_carving();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_register_extremes();
    test_mid_generation_resize();
    test_back_to_back();
    test_random_mazes();

    // Drop valid, wait out the queue, then give stray beats time to show up.
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
